// ----- rtl/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants for the bitmap priority marker: item formats,
// action codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bpm_pkg;

   // bitmap geometry
   localparam int LIST_BYTES = 16;
   localparam int ID_COUNT   = LIST_BYTES * 8;
   localparam int ID_W       = $clog2(ID_COUNT);
   localparam int BYTE_W     = $clog2(LIST_BYTES);
   localparam int COUNT_W    = 8;
   localparam int PRIO_W     = 16;

   // priority codes
   localparam logic signed [PRIO_W-1:0] PRIO_LIMIT  = 16'sd32767;
   localparam logic signed [PRIO_W-1:0] PRIO_ALWAYS = -16'sd1;

   // action codes
   localparam logic [2:0] ACT_WRITE_PRIO = 3'd0;
   localparam logic [2:0] ACT_SET_WAIT   = 3'd1;
   localparam logic [2:0] ACT_CLR_WAIT   = 3'd2;
   localparam logic [2:0] ACT_CLR_NEXT   = 3'd3;
   localparam logic [2:0] ACT_MARK       = 3'd4;

   // input item
   typedef struct packed {
      logic [2:0]               action;
      logic [ID_W-1:0]          request_id;
      logic signed [PRIO_W-1:0] priority_value;
   } req_type;

   // result item
   typedef struct packed {
      logic [BYTE_W-1:0]  byte_index;
      logic [7:0]         next_byte;
      logic [COUNT_W-1:0] waiting_count;
      logic [ID_W-1:0]    chosen_id;
      logic               chosen_valid;
      logic               last;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_APPLY,
      ST_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic exec;       // apply a non-mark action
      logic scan_init;  // start a mark
      logic scan_read;  // read one table entry
      logic apply_win;  // set the winner bit
      logic emit;       // send one byte
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_last;
      logic emit_last;
   } dp_status_type;

endpackage

// ----- rtl/bitmap_priority_marker.sv -----
// ----------------------------------------------------------------------------
// bitmap_priority_marker
// Lowest-value priority arbiter over a 128-id waiting bitmap. Items write a
// priority, set or clear a waiting bit, clear the next bitmap or run a mark;
// a mark returns the next bitmap as a run of 16 byte items.
//
//   channel   ports                       direction  handshake
//   request   start, busy, req_data       in         start && !busy
//   response  rsp_strobe, rsp_data        out        rsp_strobe, one cycle
//
// Non-mark items are applied from the idle state; busy stays low.
// A mark holds busy through its scan (one priority table read per cycle on
// its single port), a flush, the winner update and the emit of 16 bytes.
// The last byte shows in the same cycle that busy drops.
// Synchronous reset clears bitmaps and control; the table stays undefined.
// The receiver cannot stall: each result item is shown for one cycle only.
// ----------------------------------------------------------------------------
module bitmap_priority_marker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bpm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bpm_pkg::rsp_type rsp_data
);
   import bpm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // controller
   bpm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // datapath
   bpm_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule

// ----- rtl/bpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpm_ctrl
// Controller state machine: accepts items, sequences the table scan,
// the winner update and the run of result bytes.
// ----------------------------------------------------------------------------
module bpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0]             action,
   input  bpm_pkg::dp_status_type status,
   output bpm_pkg::dp_cmd_type    cmd,
   output logic                   busy
);
   import bpm_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (action == ACT_MARK) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  cmd.exec = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply_win = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/bpm_datapath.sv -----
// ----------------------------------------------------------------------------
// bpm_datapath
// Priority table memory, waiting and next bitmaps, the one-id-per-cycle
// scan unit (count, always-marks, lowest-priority pick) and the result
// register.
// ----------------------------------------------------------------------------
module bpm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bpm_pkg::req_type       req,
   input  bpm_pkg::dp_cmd_type    cmd,
   output bpm_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output bpm_pkg::rsp_type       rsp
);
   import bpm_pkg::*;

   // priority table, undefined until written
   logic signed [PRIO_W-1:0] prio_mem_ff [ID_COUNT];

   // bitmaps
   logic [7:0] waiting_ff [LIST_BYTES];
   logic [7:0] waiting_in [LIST_BYTES];
   logic [7:0] next_ff    [LIST_BYTES];
   logic [7:0] next_in    [LIST_BYTES];

   // scan control
   logic [ID_W-1:0]   scan_idx_ff;
   logic [ID_W-1:0]   scan_idx_in;
   logic              rd_valid_ff;
   logic              rd_valid_in;

   // scan read stage payload
   logic signed [PRIO_W-1:0] rd_prio_ff;
   logic [ID_W-1:0]          rd_id_ff;
   logic                     rd_wait_ff;

   // mark accumulators
   logic [COUNT_W-1:0]       count_ff;
   logic [COUNT_W-1:0]       count_in;
   logic                     found_ff;
   logic                     found_in;
   logic signed [PRIO_W-1:0] best_prio_ff;
   logic signed [PRIO_W-1:0] best_prio_in;
   logic [ID_W-1:0]          best_id_ff;
   logic [ID_W-1:0]          best_id_in;

   // emit control and result register
   logic [BYTE_W-1:0] emit_idx_ff;
   logic [BYTE_W-1:0] emit_idx_in;
   logic              rsp_strobe_ff;
   logic              rsp_strobe_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic hit;
   logic is_always;
   logic eligible;

   // table write and registered scan read
   always_ff @(posedge clock) begin
      if (cmd.exec && req.action == ACT_WRITE_PRIO) begin
         prio_mem_ff[req.request_id] <= req.priority_value;
      end
      if (cmd.scan_read) begin
         rd_prio_ff <= prio_mem_ff[scan_idx_ff];
         rd_id_ff   <= scan_idx_ff;
         rd_wait_ff <= waiting_ff[scan_idx_ff[ID_W-1:3]][scan_idx_ff[2:0]];
      end
   end

   // classify the entry read last cycle
   always_comb begin
      hit       = rd_valid_ff && rd_wait_ff;
      is_always = (rd_prio_ff == PRIO_ALWAYS);
      eligible  = (rd_prio_ff > 16'sd0) && (rd_prio_ff < best_prio_ff);
   end

   // bitmap updates
   always_comb begin
      waiting_in = waiting_ff;
      next_in    = next_ff;
      if (cmd.exec && req.action == ACT_SET_WAIT) begin
         waiting_in[req.request_id[ID_W-1:3]][req.request_id[2:0]] = 1'b1;
      end
      if (cmd.exec && req.action == ACT_CLR_WAIT) begin
         waiting_in[req.request_id[ID_W-1:3]][req.request_id[2:0]] = 1'b0;
      end
      if (cmd.exec && req.action == ACT_CLR_NEXT) begin
         for (int i = 0; i < LIST_BYTES; i++) begin
            next_in[i] = '0;
         end
      end
      if (hit && is_always) begin
         next_in[rd_id_ff[ID_W-1:3]][rd_id_ff[2:0]] = 1'b1;
      end
      if (cmd.apply_win && found_ff) begin
         next_in[best_id_ff[ID_W-1:3]][best_id_ff[2:0]] = 1'b1;
      end
   end

   // scan index, count and pick
   always_comb begin
      scan_idx_in  = scan_idx_ff;
      rd_valid_in  = cmd.scan_read;
      count_in     = count_ff;
      found_in     = found_ff;
      best_prio_in = best_prio_ff;
      best_id_in   = best_id_ff;
      if (cmd.scan_init) begin
         scan_idx_in  = '0;
         count_in     = '0;
         found_in     = 1'b0;
         best_prio_in = PRIO_LIMIT;
         best_id_in   = '0;
      end
      if (cmd.scan_read) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
      if (hit) begin
         count_in = count_ff + 1'b1;
         if (!is_always && eligible) begin
            found_in     = 1'b1;
            best_prio_in = rd_prio_ff;
            best_id_in   = rd_id_ff;
         end
      end
   end

   // result run
   always_comb begin
      emit_idx_in   = emit_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      if (cmd.scan_init) begin
         emit_idx_in = '0;
      end
      if (cmd.emit) begin
         emit_idx_in          = emit_idx_ff + 1'b1;
         rsp_strobe_in        = 1'b1;
         rsp_in.byte_index    = emit_idx_ff;
         rsp_in.next_byte     = next_ff[emit_idx_ff];
         rsp_in.waiting_count = count_ff;
         rsp_in.chosen_id     = best_id_ff;
         rsp_in.chosen_valid  = found_ff;
         rsp_in.last          = (emit_idx_ff == BYTE_W'(LIST_BYTES - 1));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIST_BYTES; i++) begin
            waiting_ff[i] <= '0;
            next_ff[i]    <= '0;
         end
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         best_prio_ff  <= PRIO_LIMIT;
         best_id_ff    <= '0;
         emit_idx_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         waiting_ff    <= waiting_in;
         next_ff       <= next_in;
         scan_idx_ff   <= scan_idx_in;
         rd_valid_ff   <= rd_valid_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
         best_prio_ff  <= best_prio_in;
         best_id_ff    <= best_id_in;
         emit_idx_ff   <= emit_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // status and outputs
   assign status.scan_last = (scan_idx_ff == ID_W'(ID_COUNT - 1));
   assign status.emit_last = (emit_idx_ff == BYTE_W'(LIST_BYTES - 1));
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp              = rsp_ff;

endmodule

// ----- rtl/bpm_checker.sv -----
// ----------------------------------------------------------------------------
// bpm_checker
// Port-level checks on the result run and the busy handshake, bound to
// the top level.
// ----------------------------------------------------------------------------
module bpm_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input bpm_pkg::req_type req_data,
   input logic             rsp_strobe,
   input bpm_pkg::rsp_type rsp_data
);
   import bpm_pkg::*;

   // a run ends after its last byte
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !rsp_strobe)
      else $error("result strobe after last byte");

   // bytes of a run come back to back in order
   a_run_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe &&
         rsp_data.byte_index == BYTE_W'($past(rsp_data.byte_index) + 1'b1))
      else $error("result run broken or out of order");

   // summary fields hold across a run
   a_run_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> $stable(rsp_data.waiting_count) &&
         $stable(rsp_data.chosen_id) && $stable(rsp_data.chosen_valid))
      else $error("result summary changed within a run");

   // an accepted mark makes the block busy
   a_mark_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == ACT_MARK |=> busy)
      else $error("mark accepted without going busy");

endmodule

bind bitmap_priority_marker bpm_checker u_bpm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- bench/bitmap_priority_marker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_priority_marker_tb
// Self-checking bench for the bitmap priority marker. A directed table walks
// the corner cases (empty mark, always-marked ids, edge priorities, ties,
// spare actions), then random action streams exercise the arbiter. Every
// accepted item runs through a behavioral mirror of the arbiter, and each
// result byte is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_priority_marker_tb;
   import bpm_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 270;
   localparam int DRAIN_CYCLES = 20;

   // action codes the block has no use for
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_MID   = 3'd6;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

   // one directed item, with an optional hand-written mark outcome
   typedef struct {
      req_type             item;
      bit                  typed;
      int                  count;
      bit                  valid;
      int                  win;
      logic [ID_COUNT-1:0] bits;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // mirror of the arbiter state
   logic signed [PRIO_W-1:0] prio_tab [ID_COUNT];
   logic [ID_COUNT-1:0]      wait_map = '0;
   logic [ID_COUNT-1:0]      next_map = '0;
   rsp_type                  byte_queue [$];

   // stimulus bookkeeping
   bit           prio_known [ID_COUNT];
   stim_row_type typed_row;
   bit           idle_on;
   int           accept_count   = 0;
   int           cycle_count    = 0;
   int           mismatch_total = 0;
   int           byte_total     = 0;
   int           mark_total     = 0;
   int           winner_total   = 0;

   bitmap_priority_marker dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic stim_row_type mk_row(logic [2:0] act, int id, int pv,
                                           bit typed = 1'b0, int count = 0,
                                           bit valid = 1'b0, int win = 0,
                                           logic [ID_COUNT-1:0] bits = '0);
      stim_row_type r;
      r.item.action         = act;
      r.item.request_id     = ID_W'(id);
      r.item.priority_value = PRIO_W'(pv);
      r.typed               = typed;
      r.count               = count;
      r.valid               = valid;
      r.win                 = win;
      r.bits                = bits;
      return r;
   endfunction

   // apply one item to the mirror; a mark queues its 16 result bytes
   task automatic arbitrate_item(input req_type it);
      logic signed [PRIO_W-1:0] best_prio;
      int                       best_id;
      int                       seen;
      bit                       found;
      rsp_type                  r;
      best_prio = PRIO_LIMIT;
      best_id   = 0;
      seen      = 0;
      found     = 1'b0;
      case (it.action)
         ACT_WRITE_PRIO: prio_tab[it.request_id] = it.priority_value;
         ACT_SET_WAIT:   wait_map[it.request_id] = 1'b1;
         ACT_CLR_WAIT:   wait_map[it.request_id] = 1'b0;
         ACT_CLR_NEXT:   next_map = '0;
         ACT_MARK: begin
            // scan upward: always-ids get marked, lowest positive value wins
            for (int i = 0; i < ID_COUNT; i++) begin
               if (wait_map[i]) begin
                  seen++;
                  if (prio_tab[i] == PRIO_ALWAYS) begin
                     next_map[i] = 1'b1;
                  end else if (prio_tab[i] > 0 && prio_tab[i] < best_prio) begin
                     best_prio = prio_tab[i];
                     best_id   = i;
                     found     = 1'b1;
                  end
               end
            end
            if (found) next_map[best_id] = 1'b1;
            mark_total++;
            if (found) winner_total++;
            // queue the run, or the hand-written outcome for a directed row
            for (int i = 0; i < LIST_BYTES; i++) begin
               r.byte_index = BYTE_W'(i);
               r.last       = (i == LIST_BYTES - 1);
               if (typed_row.typed) begin
                  r.next_byte     = typed_row.bits[i*8 +: 8];
                  r.waiting_count = COUNT_W'(typed_row.count);
                  r.chosen_id     = ID_W'(typed_row.win);
                  r.chosen_valid  = typed_row.valid;
               end else begin
                  r.next_byte     = next_map[i*8 +: 8];
                  r.waiting_count = COUNT_W'(seen);
                  r.chosen_id     = found ? ID_W'(best_id) : '0;
                  r.chosen_valid  = found;
               end
               byte_queue.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_total++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // offer one item until the block takes it, idling at random meanwhile
   task automatic send_item(input req_type it);
      int          target;
      bit          idle;
      logic [31:0] noise;
      target = accept_count + 1;
      if (it.action == ACT_WRITE_PRIO) prio_known[it.request_id] = 1'b1;
      do begin
         idle  = idle_on && ($urandom_range(0, 99) < 27);
         noise = $urandom;
         start    <= !idle;
         req_data <= idle ? req_type'(noise[$bits(req_type)-1:0]) : it;
         @(negedge clock);
      end while (accept_count != target);
   endtask

   // accept items into the mirror and check result bytes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            byte_total++;
            if (byte_queue.size() == 0) begin
               mismatch_total++;
               $display("%0t: unexpected result byte, got %p", $time, rsp_data);
            end else begin
               check_field("byte_index", byte_queue[0].byte_index, rsp_data.byte_index);
               check_field("next_byte", byte_queue[0].next_byte, rsp_data.next_byte);
               check_field("waiting_count", byte_queue[0].waiting_count,
                           rsp_data.waiting_count);
               check_field("chosen_id", byte_queue[0].chosen_id, rsp_data.chosen_id);
               check_field("chosen_valid", byte_queue[0].chosen_valid,
                           rsp_data.chosen_valid);
               check_field("last", byte_queue[0].last, rsp_data.last);
               void'(byte_queue.pop_front());
            end
         end
         if (start && !busy) begin
            accept_count++;
            arbitrate_item(req_data);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      stim_row_type plan [$];
      req_type      it;
      int           sel;
      start          = 1'b0;
      req_data       = '0;
      reset          = 1'b1;
      idle_on        = 1'b1;
      typed_row      = mk_row(ACT_MARK, 0, 0);

      // empty mark, then edge priorities and the first winner
      plan.push_back(mk_row(ACT_MARK, 0, 0, 1'b1, 0, 1'b0, 0, '0));
      plan.push_back(mk_row(ACT_WRITE_PRIO, 0, -1));
      plan.push_back(mk_row(ACT_WRITE_PRIO, 127, 32767));
      plan.push_back(mk_row(ACT_WRITE_PRIO, 5, 1));
      plan.push_back(mk_row(ACT_WRITE_PRIO, 64, 32766));
      plan.push_back(mk_row(ACT_WRITE_PRIO, 9, 0));
      plan.push_back(mk_row(ACT_WRITE_PRIO, 10, -32768));
      plan.push_back(mk_row(ACT_SET_WAIT, 0, 0));
      plan.push_back(mk_row(ACT_SET_WAIT, 127, 0));
      plan.push_back(mk_row(ACT_SET_WAIT, 5, 0));
      plan.push_back(mk_row(ACT_SET_WAIT, 64, 0));
      plan.push_back(mk_row(ACT_SET_WAIT, 9, 0));
      plan.push_back(mk_row(ACT_SET_WAIT, 10, 0));
      plan.push_back(mk_row(ACT_MARK, 0, 0, 1'b1, 6, 1'b1, 5,
                            (128'd1 << 0) | (128'd1 << 5)));
      // highest eligible priority wins once the urgent id leaves
      plan.push_back(mk_row(ACT_CLR_WAIT, 5, 0));
      plan.push_back(mk_row(ACT_MARK, 0, 0, 1'b1, 5, 1'b1, 64,
                            (128'd1 << 0) | (128'd1 << 5) | (128'd1 << 64)));
      // no eligible id left: zero, most negative and the limit value
      plan.push_back(mk_row(ACT_CLR_NEXT, 0, 0));
      plan.push_back(mk_row(ACT_CLR_WAIT, 64, 0));
      plan.push_back(mk_row(ACT_MARK, 0, 0, 1'b1, 4, 1'b0, 0, 128'd1 << 0));
      // spare actions must change nothing
      plan.push_back(mk_row(ACT_SPARE_MID, 0, 5));
      plan.push_back(mk_row(ACT_SPARE_FIRST, 64, 7));
      plan.push_back(mk_row(ACT_SPARE_LAST, 127, -1));
      // tie on value goes to the lower id
      plan.push_back(mk_row(ACT_WRITE_PRIO, 10, 2));
      plan.push_back(mk_row(ACT_WRITE_PRIO, 127, 2));
      plan.push_back(mk_row(ACT_MARK, 0, 0, 1'b1, 4, 1'b1, 10,
                            (128'd1 << 0) | (128'd1 << 10)));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (plan[k]) begin
         typed_row = plan[k];
         send_item(plan[k].item);
      end
      typed_row.typed = 1'b0;

      // random action streams, with a stretch of back-to-back items
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = !(n >= 100 && n < 170);
         it.request_id     = $urandom_range(0, 1) ? ID_W'($urandom_range(0, ID_COUNT - 1))
                                                  : ID_W'($urandom_range(0, 31));
         it.priority_value = PRIO_W'($urandom_range(0, 65535));
         sel = $urandom_range(0, 99);
         if (sel < 28)      it.action = ACT_WRITE_PRIO;
         else if (sel < 52) it.action = ACT_SET_WAIT;
         else if (sel < 64) it.action = ACT_CLR_WAIT;
         else if (sel < 71) it.action = ACT_CLR_NEXT;
         else if (sel < 94) it.action = ACT_MARK;
         else               it.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
         // an id only waits once its priority is stored
         if (it.action == ACT_SET_WAIT && !prio_known[it.request_id])
            it.action = ACT_WRITE_PRIO;
         if (it.action == ACT_WRITE_PRIO) begin
            case ($urandom_range(0, 7))
               0:       it.priority_value = PRIO_ALWAYS;
               1:       it.priority_value = PRIO_LIMIT;
               2:       it.priority_value = PRIO_LIMIT - 16'sd1;
               3:       it.priority_value = 16'sd1;
               4, 5:    it.priority_value = PRIO_W'($urandom_range(1, 12));
               default: ;
            endcase
         end
         send_item(it);
      end

      // drain
      start <= 1'b0;
      while (byte_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d items and %0d marks, %0d of them with a winner",
               accept_count, mark_total, winner_total);
      $display("checked %0d result bytes, %0d mismatches", byte_total, mismatch_total);
      if (mismatch_total == 0 && byte_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
